// ===== src/histogram_mean_luminance_core_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the histogram mean luminance core
// Clocked, reset-gated property checks that report through $error.
// ---------------------------------------------------------------------------
`ifndef HISTOGRAM_MEAN_LUMINANCE_CORE_ASSERT_SVH
`define HISTOGRAM_MEAN_LUMINANCE_CORE_ASSERT_SVH

// Check that a property holds at every clock edge outside reset.
`define HML_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a consequent holds in the same cycle as its antecedent.
`define HML_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== src/hml_pkg.sv =====
// ---------------------------------------------------------------------------
// Histogram mean luminance package
// Request types, queue entry type and the linear luminance table per bin.
// ---------------------------------------------------------------------------
package hml_pkg;

  localparam int unsigned Bins   = 32;
  localparam int unsigned IdxW   = $clog2(Bins + 1);
  localparam int unsigned RomAw  = $clog2(Bins);
  localparam int unsigned PixW   = 40;
  localparam int unsigned WgtW   = 56;
  localparam int unsigned ProdW  = 48;
  localparam int unsigned NumW   = 64;
  localparam int unsigned QuoW   = 15;
  localparam int unsigned CntW   = $clog2(QuoW);

  localparam logic [63:0] Span    = 64'(Bins - 1);
  localparam logic [63:0] LinDen  = 64'd1292 * Span;
  localparam logic [63:0] LinDen2 = 64'd2 * LinDen;
  localparam logic [63:0] GamDen  = 64'd1055 * Span;
  localparam logic [63:0] GamHalf = GamDen / 64'd2;
  localparam logic [63:0] Q30One  = 64'd1 << 30;

  typedef struct packed {
    logic [31:0] bin_count;
    logic        last_bin;
  } hml_in_t;

  typedef struct packed {
    logic [14:0] mean_luminance;
    logic        empty_res;
    logic        overrun;
  } hml_out_t;

  typedef struct packed {
    logic [31:0] count;
    logic [15:0] weight;
    logic        last;
    logic        ovr;
  } hml_entry_t;

  typedef logic [15:0] lum_rom_t [Bins];

  function automatic logic [63:0] mul_q30(logic [63:0] a, logic [63:0] b);
    return (a * b + (64'd1 << 29)) >> 30;
  endfunction

  function automatic logic [63:0] pow5_q30(logic [63:0] r);
    logic [63:0] p;
    p = mul_q30(r, r);
    p = mul_q30(p, r);
    p = mul_q30(p, r);
    return mul_q30(p, r);
  endfunction

  function automatic logic [15:0] decode_entry(logic [63:0] i);
    logic [63:0] v;
    logic [63:0] n;
    logic [63:0] t;
    logic [63:0] t2;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    if (64'd100000 * i <= 64'd4045 * Span) begin
      v = (i * 64'd13107200 + LinDen) / LinDen2;
    end else begin
      n  = 64'd1000 * i + 64'd55 * Span;
      t  = ((n << 30) + GamHalf) / GamDen;
      lo = 64'd0;
      hi = Q30One;
      if (t > Q30One) t = Q30One;
      t2 = mul_q30(t, t);
      for (int s = 0; s < 32; s++) begin
        if (lo < hi) begin
          mid = (lo + hi + 64'd1) >> 1;
          if (pow5_q30(mid) <= t2) lo = mid;
          else hi = mid - 64'd1;
        end
      end
      v = (mul_q30(t2, lo) + (64'd1 << 13)) >> 14;
    end
    if (v > 64'd65535) v = 64'd65535;
    return v[15:0];
  endfunction

  function automatic lum_rom_t build_lum_rom();
    lum_rom_t rom;
    for (int k = 0; k < Bins; k++) begin
      rom[k] = decode_entry(64'(k));
    end
    return rom;
  endfunction

  localparam lum_rom_t LumRom = build_lum_rom();

endpackage

// ===== src/hml_front.sv =====
// ---------------------------------------------------------------------------
// Histogram mean luminance front end
// Tracks the bin position, looks up the bin weight and flags overrun bins.
// ---------------------------------------------------------------------------
module hml_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  hml_pkg::hml_in_t    in_req_i,
  output logic                push_o,
  input  logic                push_ready_i,
  output hml_pkg::hml_entry_t push_entry_o
);
  import hml_pkg::*;

  logic [IdxW-1:0] idx_q, idx_d;
  logic            ovr_q, ovr_d;
  logic            in_range;
  logic            accept;

  assign in_ready_o = push_ready_i;
  assign accept     = in_valid_i && push_ready_i;
  assign push_o     = accept;
  assign in_range   = idx_q < IdxW'(Bins);

  always_comb begin
    push_entry_o.count  = in_range ? in_req_i.bin_count : '0;
    push_entry_o.weight = in_range ? LumRom[idx_q[RomAw-1:0]] : '0;
    push_entry_o.last   = in_req_i.last_bin;
    push_entry_o.ovr    = ovr_q || !in_range;
  end

  always_comb begin
    idx_d = idx_q;
    ovr_d = ovr_q;
    if (accept) begin
      if (in_req_i.last_bin) begin
        idx_d = '0;
        ovr_d = 1'b0;
      end else if (in_range) begin
        idx_d = idx_q + IdxW'(1);
      end else begin
        ovr_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      ovr_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      ovr_q <= ovr_d;
    end
  end

endmodule

// ===== src/hml_queue.sv =====
// ---------------------------------------------------------------------------
// Histogram mean luminance queue
// Four-entry register queue between the front end and the back end.
// ---------------------------------------------------------------------------
module hml_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  output logic                push_ready_o,
  input  hml_pkg::hml_entry_t push_entry_i,
  output logic                pop_valid_o,
  input  logic                pop_i,
  output hml_pkg::hml_entry_t pop_entry_o
);
  import hml_pkg::*;

  localparam int unsigned Depth = 4;
  localparam int unsigned PtrW  = $clog2(Depth);

  hml_entry_t      mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d;
  logic [PtrW-1:0] rd_q, rd_d;
  logic [PtrW:0]   fill_q, fill_d;
  logic            do_push;
  logic            do_pop;

  assign push_ready_o = fill_q != (PtrW + 1)'(Depth);
  assign pop_valid_o  = fill_q != '0;
  assign pop_entry_o  = mem_q[rd_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  always_comb begin
    wr_d   = do_push ? wr_q + PtrW'(1) : wr_q;
    rd_d   = do_pop ? rd_q + PtrW'(1) : rd_q;
    fill_d = fill_q;
    if (do_push && !do_pop) fill_d = fill_q + (PtrW + 1)'(1);
    else if (!do_push && do_pop) fill_d = fill_q - (PtrW + 1)'(1);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push_entry_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      wr_q   <= wr_d;
      rd_q   <= rd_d;
      fill_q <= fill_d;
    end
  end

endmodule

// ===== src/hml_back.sv =====
// ---------------------------------------------------------------------------
// Histogram mean luminance back end
// Weights and sums the bins, then divides once per histogram for the mean.
// ---------------------------------------------------------------------------
module hml_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                pop_valid_i,
  output logic                pop_o,
  input  hml_pkg::hml_entry_t pop_entry_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output hml_pkg::hml_out_t   out_req_o
);
  import hml_pkg::*;

  typedef enum logic [3:0] {
    S_RUN  = 4'b0001,
    S_PREP = 4'b0010,
    S_DIV  = 4'b0100,
    S_OUT  = 4'b1000
  } state_e;

  state_e           state_q, state_d;
  logic             s1_valid_q;
  logic             s1_last_q;
  logic             s1_ovr_q;
  logic [31:0]      s1_cnt_q;
  logic [ProdW-1:0] s1_prod_q;
  logic [PixW-1:0]  pix_q, pix_d;
  logic [WgtW-1:0]  wgt_q, wgt_d;
  logic             ovr_q, ovr_d;
  logic             empty_q, empty_d;
  logic [NumW-1:0]  rem_q, rem_d;
  logic [NumW-1:0]  dsh_q, dsh_d;
  logic [QuoW-1:0]  quo_q, quo_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  hml_out_t         out_q, out_d;
  logic [NumW-1:0]  wgt_ext;
  logic             ge;

  assign pop_o       = (state_q == S_RUN) && pop_valid_i && !(s1_valid_q && s1_last_q);
  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;
  assign wgt_ext     = NumW'(wgt_q);
  assign ge          = rem_q >= dsh_q;

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s1_prod_q <= ProdW'(pop_entry_i.count) * ProdW'(pop_entry_i.weight);
      s1_cnt_q  <= pop_entry_i.count;
      s1_last_q <= pop_entry_i.last;
      s1_ovr_q  <= pop_entry_i.ovr;
    end
  end

  always_comb begin
    state_d     = state_q;
    pix_d       = pix_q;
    wgt_d       = wgt_q;
    ovr_d       = ovr_q;
    empty_d     = empty_q;
    rem_d       = rem_q;
    dsh_d       = dsh_q;
    quo_d       = quo_q;
    cnt_d       = cnt_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      S_RUN: begin
        if (s1_valid_q) begin
          pix_d = pix_q + PixW'(s1_cnt_q);
          wgt_d = wgt_q + WgtW'(s1_prod_q);
          if (s1_last_q) begin
            ovr_d   = s1_ovr_q;
            state_d = S_PREP;
          end
        end
      end
      S_PREP: begin
        rem_d   = (wgt_ext << 7) + (wgt_ext << 6) + (wgt_ext << 3) + (NumW'(pix_q) << 8);
        dsh_d   = NumW'(pix_q) << (9 + QuoW - 1);
        empty_d = pix_q == '0;
        quo_d   = '0;
        cnt_d   = CntW'(QuoW - 1);
        pix_d   = '0;
        wgt_d   = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        rem_d = ge ? rem_q - dsh_q : rem_q;
        quo_d = {quo_q[QuoW-2:0], ge};
        dsh_d = dsh_q >> 1;
        cnt_d = cnt_q - CntW'(1);
        if (cnt_q == '0) state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_d.mean_luminance = empty_q ? '0 : quo_q;
          out_d.empty_res      = empty_q;
          out_d.overrun        = ovr_q;
          out_valid_d          = 1'b1;
          state_d              = S_RUN;
        end
      end
      default: state_d = S_RUN;
    endcase
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsh_q <= dsh_d;
    quo_q <= quo_d;
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_RUN;
      s1_valid_q  <= 1'b0;
      pix_q       <= '0;
      wgt_q       <= '0;
      ovr_q       <= 1'b0;
      empty_q     <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      s1_valid_q  <= pop_o;
      pix_q       <= pix_d;
      wgt_q       <= wgt_d;
      ovr_q       <= ovr_d;
      empty_q     <= empty_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  `include "histogram_mean_luminance_core_assert.svh"

  `HML_ASSERT_IMPL(a_pop_in_run, pop_o, state_q == S_RUN, "pop outside run state")
  `HML_ASSERT_IMPL(a_div_count, state_q == S_DIV, cnt_q <= CntW'(QuoW - 1), "divider count out of range")
  `HML_ASSERT_IMPL(a_mean_range, out_valid_q, out_q.mean_luminance <= 15'd25600, "mean above full scale")
  `HML_ASSERT_IMPL(a_empty_zero, out_valid_q && out_q.empty_res, out_q.mean_luminance == '0, "empty result not zero")

endmodule

// ===== src/histogram_mean_luminance_core.sv =====
// ---------------------------------------------------------------------------
// Histogram mean luminance core
// Mean linear luminance percent in Q8.8 from a stream of histogram bins.
// ---------------------------------------------------------------------------
// Input channel: one request per histogram bin, in bin order, with last_bin
// set on the final bin. Bins are taken one per cycle while the queue has
// room; the front end weights each bin from a constant sRGB-decode table
// and queues it (four entries). Output channel: one request per histogram,
// after the last bin, carrying the mean, the empty flag and the overrun flag
// (bins beyond 32 dropped). From the last bin to the result the path runs
// through the queue, one multiply stage, one accumulate, a setup state and
// a 15-step restoring divider. The divider is the bottleneck: the back end
// takes no new bins until a histogram's result is out; during the divide no
// bins leave the queue, and the input stalls once the queue is full.
// A result waits in the output register while out_ready_i is low; the
// back end then holds the next result and the queue absorbs new bins.
// Reset clears the bin position, sums, flags and all valid state.
// ---------------------------------------------------------------------------
module histogram_mean_luminance_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  hml_pkg::hml_in_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output hml_pkg::hml_out_t out_req_o
);
  import hml_pkg::*;

  logic       push;
  logic       push_ready;
  hml_entry_t push_entry;
  logic       pop_valid;
  logic       pop;
  hml_entry_t pop_entry;

  hml_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_req_i     (in_req_i),
    .push_o       (push),
    .push_ready_i (push_ready),
    .push_entry_o (push_entry)
  );

  hml_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .push_entry_i (push_entry),
    .pop_valid_o  (pop_valid),
    .pop_i        (pop),
    .pop_entry_o  (pop_entry)
  );

  hml_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_o       (pop),
    .pop_entry_i (pop_entry),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_req_o   (out_req_o)
  );

endmodule
